/* rtl/bra_pkg.sv */
// Package for the best rational approximation unit: field widths, reset
// values and the sequencer state type. No dependencies.
package bra_pkg;

	localparam int VALUE_W = 48;
	localparam int NUM_W   = 16;
	localparam int DEN_W   = 8;

	localparam int INT_BITS_DEF  = 16;
	localparam int FRAC_BITS_DEF = 32;

	localparam logic [DEN_W-1:0] MAX_DEN_RESET = 8'd32;
	localparam logic [NUM_W-1:0] NUM_MAX       = 16'hFFFF;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV,
		ST_MUL_D,
		ST_MUL_N,
		ST_DONE
	} bra_state_t;

endpackage

/* rtl/best_rational_approximation_unit.sv */
// Best rational approximation: continued-fraction convergents of a fixed-point
// value with a bounded denominator. Depends on bra_pkg.
//
//  channel      | dir | handshake                    | payload
//  s_axis       | in  | s_axis_tvalid/s_axis_tready  | tdata[47:0] = value
//  m_axis       | out | m_axis_tvalid/m_axis_tready  | tdata[15:0] numerator, [23:16] denominator
//  cfg          | in  | cfg_wr_en                    | cfg_wr_data[7:0] = max_denominator
//
// One transaction runs a check and then one Euclid step per partial quotient,
// about a dozen steps at most for denominators up to 255 with a Q16.32 value.
// The step time is set by the one-bit-per-cycle restoring divider;
// one shared 8x16 multiplier then forms the next denominator and numerator.
// s_axis_tready is high only while the sequencer is idle; a finished result
// waits in the output register, and the next transaction may be taken meanwhile.
// Reset clears the sequencer, the output valid and sets max_denominator to 32.
module best_rational_approximation_unit #(
	parameter int INT_BITS  = bra_pkg::INT_BITS_DEF,
	parameter int FRAC_BITS = bra_pkg::FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	input  logic [bra_pkg::VALUE_W-1:0]  s_axis_tdata,  // [47:0] value
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	output logic [23:0]                  m_axis_tdata,  // [15:0] numerator, [23:16] denominator
	input  logic                         cfg_wr_en,
	input  logic [bra_pkg::DEN_W-1:0]    cfg_wr_data
);
	import bra_pkg::*;

	localparam int CNT_W  = $clog2(FRAC_BITS + 1);
	localparam int FULL_W = INT_BITS + FRAC_BITS + VALUE_W;
	localparam int CMP_W  = INT_BITS + DEN_W;
	localparam int SAT_W  = INT_BITS + NUM_W;
	localparam int PROD_W = DEN_W + NUM_W;

	bra_state_t state_q, state_d;

	logic [DEN_W-1:0]     maxd_q;
	logic [INT_BITS-1:0]  a0_q;
	logic [FRAC_BITS:0]   div_q;    // current dividend, up to 2^FRAC_BITS
	logic [FRAC_BITS-1:0] rem_q;    // current divisor
	logic [FRAC_BITS-1:0] pr_q;     // partial remainder
	logic [FRAC_BITS:0]   dq_q;     // dividend bits out, quotient bits in
	logic [CNT_W-1:0]     cnt_q;
	logic [NUM_W-1:0]     n0_q, n1_q;
	logic [DEN_W-1:0]     d0_q, d1_q, d2_q;
	logic [NUM_W-1:0]     res_num_q;
	logic [DEN_W-1:0]     res_den_q;
	logic [NUM_W-1:0]     out_num_q;
	logic [DEN_W-1:0]     out_den_q;
	logic                 out_vld_q;

	logic [FULL_W-1:0]    v_full;
	logic                 int_case;
	logic                 stop_loop;
	logic [FRAC_BITS:0]   trial;
	logic                 q_bit;
	logic [DEN_W-1:0]     ai;
	logic                 ai_big;
	logic [NUM_W-1:0]     mul_b;
	logic [PROD_W-1:0]    prod;
	logic [PROD_W:0]      d2_w;
	logic [PROD_W:0]      n2_w;
	logic                 d2_over;
	logic                 out_free;
	logic [NUM_W-1:0]     a0_sat;

	assign v_full = FULL_W'(s_axis_tdata);

	assign int_case  = CMP_W'(a0_q) > CMP_W'(maxd_q);
	assign stop_loop = (rem_q == '0) || (d1_q > maxd_q);
	assign a0_sat    = (SAT_W'(a0_q) > SAT_W'(NUM_MAX)) ? NUM_MAX : NUM_W'(a0_q);

	// restoring divider step
	assign trial = {pr_q, dq_q[FRAC_BITS]};
	assign q_bit = trial >= {1'b0, rem_q};

	// partial quotient above 255 can never give a fitting denominator
	assign ai     = dq_q[DEN_W-1:0];
	assign ai_big = |dq_q[FRAC_BITS:DEN_W];

	// shared multiplier: denominator product first, then numerator product
	assign mul_b   = (state_q == ST_MUL_D) ? NUM_W'(d1_q) : n1_q;
	assign prod    = PROD_W'(ai) * PROD_W'(mul_b);
	assign d2_w    = {1'b0, prod} + (PROD_W+1)'(d0_q);
	assign n2_w    = {1'b0, prod} + (PROD_W+1)'(n0_q);
	assign d2_over = ai_big || (d2_w > (PROD_W+1)'(maxd_q));

	assign out_free = !out_vld_q || m_axis_tready;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {out_den_q, out_num_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_axis_tvalid) state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (int_case || stop_loop) state_d = ST_DONE;
				else state_d = ST_DIV;
			end
			ST_DIV: begin
				if (cnt_q == '0) state_d = ST_MUL_D;
			end
			ST_MUL_D: begin
				if (d2_over) state_d = ST_DONE;
				else state_d = ST_MUL_N;
			end
			ST_MUL_N: begin
				state_d = ST_CHECK;
			end
			ST_DONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			maxd_q <= MAX_DEN_RESET;
		end else if (cfg_wr_en) begin
			maxd_q <= cfg_wr_data;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_vld_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			out_num_q <= res_num_q;
			out_den_q <= res_den_q;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (s_axis_tvalid) begin
					a0_q  <= v_full[INT_BITS+FRAC_BITS-1:FRAC_BITS];
					rem_q <= v_full[FRAC_BITS-1:0];
					div_q <= {1'b1, {FRAC_BITS{1'b0}}};
					n0_q  <= NUM_W'(1);
					d0_q  <= '0;
					n1_q  <= NUM_W'(v_full[INT_BITS+FRAC_BITS-1:FRAC_BITS]);
					d1_q  <= DEN_W'(1);
				end
			end
			ST_CHECK: begin
				if (int_case) begin
					res_num_q <= a0_sat;
					res_den_q <= DEN_W'(1);
				end else begin
					res_num_q <= n1_q;
					res_den_q <= d1_q;
				end
				pr_q  <= '0;
				dq_q  <= div_q;
				cnt_q <= CNT_W'(FRAC_BITS);
			end
			ST_DIV: begin
				pr_q  <= q_bit ? FRAC_BITS'(trial - {1'b0, rem_q}) : FRAC_BITS'(trial);
				dq_q  <= {dq_q[FRAC_BITS-1:0], q_bit};
				cnt_q <= cnt_q - CNT_W'(1);
			end
			ST_MUL_D: begin
				if (d2_over) begin
					res_num_q <= n1_q;
					res_den_q <= d1_q;
				end
				d2_q <= DEN_W'(d2_w);
			end
			ST_MUL_N: begin
				n0_q  <= n1_q;
				d0_q  <= d1_q;
				n1_q  <= NUM_W'(n2_w);
				d1_q  <= d2_q;
				div_q <= {1'b0, rem_q};
				rem_q <= pr_q;
			end
			default: begin
			end
		endcase
	end

	// partial remainder stays below the divisor through the whole division
	a_pr_below_rem: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> pr_q < rem_q)
		else $error("partial remainder not below divisor");

	// Euclid steps run only with a nonzero remainder and a fitting denominator
	a_loop_guard: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV || state_q == ST_MUL_D || state_q == ST_MUL_N)
		|-> (rem_q != '0 && d1_q <= maxd_q))
		else $error("Euclid step without valid loop condition");

	// an accepted convergent never lowers the denominator or exceeds the limit
	a_den_grows: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MUL_N |-> (d2_q >= d1_q && d2_q <= maxd_q))
		else $error("next denominator out of order");

	// a result never carries a zero denominator
	a_den_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[23:16] != '0)
		else $error("zero denominator in result");

	// an accepted transaction starts the sequencer in the next cycle
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> state_q == ST_CHECK)
		else $error("sequencer did not start");

endmodule

/* dv/bra_checker.sv */
// Checker for the best rational approximation unit: watches the config port and both
// stream channels, predicts each fraction and compares it with the returned one.
// Depends on bra_pkg.
module bra_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	input  logic                        s_axis_tready,
	input  logic [bra_pkg::VALUE_W-1:0] s_axis_tdata,   // [47:0] value
	input  logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	input  logic [23:0]                 m_axis_tdata,   // [15:0] numerator, [23:16] denominator
	input  logic                        cfg_wr_en,
	input  logic [bra_pkg::DEN_W-1:0]   cfg_wr_data,
	output int                          fail_count,
	output int                          pending
);
	import bra_pkg::*;

	typedef struct packed {
		logic [DEN_W-1:0] den;
		logic [NUM_W-1:0] num;
	} fraction_t;

	typedef struct {
		logic [VALUE_W-1:0] value;
		logic [DEN_W-1:0]   limit;
		fraction_t          frac;
	} expected_fraction_t;

	logic [DEN_W-1:0]   den_limit;
	expected_fraction_t fraction_q[$];
	int                 reported;

	// Last continued-fraction convergent whose denominator stays within limit.
	function automatic fraction_t best_fraction(input logic [VALUE_W-1:0] value,
			input logic [DEN_W-1:0] limit);
		bit [63:0] v, unit, whole, rem, divisor, quot, next_rem;
		bit [63:0] n_prev, d_prev, n_cur, d_cur, n_next, d_next;
		bit        done;
		fraction_t f;
		v = 64'(value) & ((64'd1 << (INT_BITS_DEF + FRAC_BITS_DEF)) - 64'd1);
		unit = 64'd1 << FRAC_BITS_DEF;
		whole = v >> FRAC_BITS_DEF;
		rem = v & (unit - 64'd1);
		n_prev = 64'd1;
		d_prev = 64'd0;
		n_cur = whole;
		d_cur = 64'd1;
		divisor = unit;
		done = 1'b0;
		// integer part alone already beyond the limit: answer is whole/1
		if (whole > 64'(limit))
			done = 1'b1;
		while (!done && rem != 64'd0 && d_cur <= 64'(limit)) begin
			quot = divisor / rem;
			next_rem = divisor % rem;
			n_next = n_prev + quot * n_cur;
			d_next = d_prev + quot * d_cur;
			if (d_next > 64'(limit)) begin
				done = 1'b1;
			end else begin
				n_prev = n_cur;
				d_prev = d_cur;
				n_cur = n_next;
				d_cur = d_next;
				divisor = rem;
				rem = next_rem;
			end
		end
		f.num = (n_cur > 64'(NUM_MAX)) ? NUM_MAX : n_cur[NUM_W-1:0];
		f.den = d_cur[DEN_W-1:0];
		return f;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		expected_fraction_t exp_item;
		fraction_t          got;
		if (!arst_n) begin
			den_limit = MAX_DEN_RESET;
			fraction_q.delete();
			fail_count = 0;
			reported = 0;
			pending = 0;
		end else begin
			if (cfg_wr_en)
				den_limit = cfg_wr_data;
			// retire the oldest expectation before queuing a new one
			if (m_axis_tvalid && m_axis_tready) begin
				got = fraction_t'(m_axis_tdata);
				if (fraction_q.size() == 0) begin
					fail_count++;
					if (reported < 10) begin
						reported++;
						$display("unexpected result %0d/%0d at %0t", got.num, got.den, $realtime);
					end
				end else begin
					exp_item = fraction_q.pop_front();
					if (got.num !== exp_item.frac.num || got.den !== exp_item.frac.den) begin
						fail_count++;
						if (reported < 10) begin
							reported++;
							$display("mismatch: value %h max_den %0d expected %0d/%0d got %0d/%0d",
								exp_item.value, exp_item.limit, exp_item.frac.num,
								exp_item.frac.den, got.num, got.den);
						end
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				exp_item.value = s_axis_tdata;
				exp_item.limit = den_limit;
				exp_item.frac = best_fraction(s_axis_tdata, den_limit);
				fraction_q.push_back(exp_item);
			end
			pending = fraction_q.size();
		end
	end

endmodule

/* dv/tb_best_rational_approximation_unit.sv */
// Testbench top for the best rational approximation unit: clock, reset, stream stimulus
// with random idling, config phases, watchdog and verdict. Depends on bra_pkg,
// best_rational_approximation_unit and bra_checker.
module tb_best_rational_approximation_unit;
	import bra_pkg::*;

	localparam int PHASES          = 8;
	localparam int ITEMS_PER_PHASE = 116;
	localparam int DRAIN_CYCLES    = 64;
	localparam int RX_HOLD_CYCLES  = 3000;
	localparam int WATCHDOG_LIMIT  = 40000;

	logic               clk;
	logic               arst_n;
	logic               s_axis_tvalid;
	logic               s_axis_tready;
	logic [VALUE_W-1:0] s_axis_tdata;   // [47:0] value
	logic               m_axis_tvalid;
	logic               m_axis_tready;
	logic [23:0]        m_axis_tdata;   // [15:0] numerator, [23:16] denominator
	logic               cfg_wr_en;
	logic [DEN_W-1:0]   cfg_wr_data;

	int   fail_count;
	int   pending;
	int   idle_run = 0;
	logic tx_steady;
	logic rx_steady;
	logic rx_hold_req;

	best_rational_approximation_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data)
	);

	bra_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.fail_count    (fail_count),
		.pending       (pending)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// mostly short gaps, some medium, a few long
	function automatic int pick_gap_len();
		int sel;
		sel = $urandom_range(0, 19);
		if (sel < 15)
			return $urandom_range(1, 3);
		else if (sel < 19)
			return $urandom_range(8, 40);
		else
			return $urandom_range(100, 500);
	endfunction

	function automatic logic [VALUE_W-1:0] random_value(input logic [DEN_W-1:0] limit);
		logic [15:0] whole;
		logic [31:0] frac;
		logic [63:0] raw;
		int          shift;
		whole = 16'($urandom_range(0, limit));
		frac = $urandom;
		case ($urandom_range(0, 9))
			6: begin
				// dyadic fraction, expansion ends on a zero remainder
				shift = $urandom_range(1, 8);
				frac = ($urandom & ((32'd1 << shift) - 32'd1)) << (32 - shift);
			end
			7: begin
				raw = {$urandom, $urandom};
				whole = raw[47:32];
				frac = raw[31:0];
			end
			8: begin
				// just above or just below an integer
				if ($urandom_range(0, 1))
					frac = 32'($urandom_range(0, 255));
				else
					frac = ~32'($urandom_range(0, 255));
			end
			9: whole = 16'(limit) + 16'($urandom_range(1, 3));
			default: ;
		endcase
		return {whole, frac};
	endfunction

	// Called and returns at a falling edge; tvalid stays high after the transaction.
	task automatic push_value(input logic [VALUE_W-1:0] v);
		int gap;
		gap = 0;
		if (!tx_steady && $urandom_range(0, 2) == 0)
			gap = pick_gap_len();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= VALUE_W'({$urandom, $urandom});
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= v;
		do
			@(posedge clk);
		while (!s_axis_tready);
		@(negedge clk);
	endtask

	task automatic await_drain();
		s_axis_tvalid <= 1'b0;
		wait (pending == 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_limit(input logic [DEN_W-1:0] limit);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= limit;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// receiver: random stalls, steady stretches, one long hold-off on request
	initial begin
		int n;
		bit hold_done;
		hold_done = 1'b0;
		m_axis_tready = 1'b0;
		@(negedge clk);
		forever begin
			if (rx_hold_req && !hold_done) begin
				hold_done = 1'b1;
				m_axis_tready <= 1'b0;
				n = RX_HOLD_CYCLES;
			end else if (!rx_steady && $urandom_range(0, 3) == 0) begin
				m_axis_tready <= 1'b0;
				n = pick_gap_len();
			end else begin
				m_axis_tready <= 1'b1;
				n = $urandom_range(1, 8);
			end
			repeat (n) @(negedge clk);
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_wr_en)
			idle_run <= 0;
		else
			idle_run <= idle_run + 1;
		if (idle_run >= WATCHDOG_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		logic [DEN_W-1:0] limit;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		tx_steady = 1'b0;
		rx_steady = 1'b0;
		rx_hold_req = 1'b0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed values at the reset limit of 32
		push_value(48'h0000_0000_0000);
		push_value(48'hFFFF_FFFF_FFFF);
		push_value(48'h0000_0000_0001);
		push_value(48'h0000_FFFF_FFFF);
		push_value(48'h0001_0000_0000);
		push_value(48'h0020_0000_0000);
		push_value(48'h0020_FFFF_FFFF);
		push_value(48'h0021_0000_0000);
		push_value(48'h0000_8000_0000);
		push_value(48'h0000_5555_5555);
		push_value(48'h0003_243F_6A89);  // pi
		push_value(48'h0001_9E37_79B9);  // golden ratio
		push_value(48'h0001_6A09_E667);  // sqrt 2
		push_value(48'h0003_4000_0000);  // 13/4 exactly
		push_value(48'h0000_0800_0000);  // 1/32 exactly
		push_value(48'h0000_07FF_FFFF);
		push_value(48'h0007_0000_0000);
		push_value(48'hAAAA_AAAA_AAAA);
		push_value(48'h5555_5555_5555);
		push_value(48'h0000_0842_1084);  // near 1/31
		await_drain();

		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: limit = 8'd255;
				1: limit = 8'd1;
				2: limit = 8'd0;
				default: limit = DEN_W'($urandom_range(1, 255));
			endcase
			write_limit(limit);
			// first phase: sender never idles while the receiver holds off, filling the unit
			tx_steady = (phase == 0) || ($urandom_range(0, 3) == 0);
			rx_steady = (phase != 0) && ($urandom_range(0, 3) == 0);
			if (phase == 0)
				rx_hold_req = 1'b1;
			repeat (ITEMS_PER_PHASE) push_value(random_value(limit));
			await_drain();
		end

		if (fail_count == 0 && pending == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
